FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file hll_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on clk, quiet while rst is high
`define HLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define HLL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/hll_pkg.sv
// shared types and constants of the hyperloglog sketch
package hll_pkg;

  localparam int PRECISION_BITS_DEF    = 12;
  localparam int SUM_FRACTION_BITS_DEF = 64;
  localparam int MAX_PRECISION         = 16;
  localparam int HASH_W                = 64;
  localparam int INDEX_W               = 12;
  localparam int RANK_W                = 6;
  localparam int EST_W                 = 64;
  localparam int QUEUE_DEPTH           = 4;
  // round(ln2 * 2^32)
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_EST   = 2'd2
  } hll_cmd_t;

  // one queued job: a table update or an estimate request
  typedef struct packed {
    logic                      is_est;
    logic [MAX_PRECISION-1:0]  slot;
    logic [RANK_W-1:0]         rank;
  } hll_job_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_UPD,
    B_SUM,
    B_LIM,
    B_TEST,
    B_DIV,
    B_ROUND,
    B_LC,
    B_DONE
  } hll_back_state_t;

  typedef enum logic [2:0] {
    LC_IDLE,
    LC_SQ,
    LC_M1,
    LC_M2,
    LC_DONE
  } hll_lc_state_t;

endpackage

FILE: rtl/core/hll_lcount.sv
// linear counting unit: m * ln(m / zeros) by repeated squaring
module hll_lcount import hll_pkg::*; #(
  parameter int PRECISION_BITS = PRECISION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PRECISION_BITS:0]   zeros,
  output logic                      done,
  output logic [EST_W-1:0]          result
);

  localparam int K_W = $clog2(PRECISION_BITS + 1);
  localparam int D_W = K_W + 32;
  localparam logic [K_W-1:0] P_K = K_W'(PRECISION_BITS);

  hll_lc_state_t state, state_next;
  logic [31:0]    y;
  logic [31:0]    frac;
  logic [4:0]     iter;
  logic [K_W-1:0] k_r;
  logic [63:0]    plo;

  logic [K_W-1:0] k;
  logic [63:0]    sq;
  logic [32:0]    ysq;
  logic [D_W-1:0] d;
  logic [63:0]    t;

  // floor(log2(zeros))
  always_comb begin
    k = '0;
    for (int i = 0; i <= PRECISION_BITS; i++) begin
      if (zeros[i]) k = K_W'(i);
    end
  end

  assign sq  = {32'd0, y} * {32'd0, y};
  assign ysq = sq[63:31];
  assign d   = {P_K, 32'd0} - {k_r, frac};
  assign t   = 64'(d[D_W-1:32]) * 64'(LN2_Q32) + 64'(plo[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      LC_IDLE: if (start) state_next = LC_SQ;
      LC_SQ:   if (iter == 5'd31) state_next = LC_M1;
      LC_M1:   state_next = LC_M2;
      LC_M2:   state_next = LC_DONE;
      LC_DONE: state_next = LC_IDLE;
      default: state_next = LC_IDLE;
    endcase
  end

  assign done = (state == LC_DONE);

  always_ff @(posedge clk) begin
    case (state)
      LC_IDLE: begin
        y    <= 32'(zeros) << (31 - k);
        k_r  <= k;
        frac <= '0;
        iter <= '0;
      end
      LC_SQ: begin
        // one fraction bit of log2 per squaring
        if (ysq[32]) begin
          y    <= ysq[32:1];
          frac <= {frac[30:0], 1'b1};
        end else begin
          y    <= ysq[31:0];
          frac <= {frac[30:0], 1'b0};
        end
        iter <= iter + 5'd1;
      end
      LC_M1: plo <= 64'(d[31:0]) * 64'(LN2_Q32);
      LC_M2: result <= ((t << PRECISION_BITS) + 64'h0000_0000_8000_0000) >> 32;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/hll_back.sv
// back end: rank table, updates, table walk, divider and result register
module hll_back import hll_pkg::*; #(
  parameter int PRECISION_BITS    = PRECISION_BITS_DEF,
  parameter int SUM_FRACTION_BITS = SUM_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  hll_job_t         job,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EST_W-1:0] estimate,
  output logic             used_linear_counting
);

  localparam int DEPTH  = 1 << PRECISION_BITS;
  localparam int CNT_W  = PRECISION_BITS + 1;
  localparam int ACC_W  = PRECISION_BITS + 1 + SUM_FRACTION_BITS;
  localparam int NUM_W  = 2 * PRECISION_BITS + SUM_FRACTION_BITS;
  localparam int LIM_W  = ACC_W + 3 + PRECISION_BITS;
  localparam int DCNT_W = $clog2(NUM_W);

  // alpha in q32: fixed values for small tables, else 0.7213 / (1 + 1.079/m)
  localparam logic [63:0] M     = 64'd1 << PRECISION_BITS;
  localparam bit          SMALL = (M == 64'd16) || (M == 64'd32) || (M == 64'd64);
  localparam logic [63:0] ANUM  = (M == 64'd16) ? (64'd673 << 32) :
                                  (M == 64'd32) ? (64'd697 << 32) :
                                  (M == 64'd64) ? (64'd709 << 32) :
                                  ((64'd7213 * M) << 32);
  localparam logic [63:0] ADEN  = SMALL ? 64'd1000 : 64'd10 * (64'd1000 * M + 64'd1079);
  localparam logic [63:0] ALPHA = (ANUM + ADEN / 2) / ADEN;
  // alpha * m^2 scaled to the sum's fraction bits
  localparam logic [NUM_W-1:0] NUM =
    NUM_W'(ALPHA) << (2 * PRECISION_BITS + SUM_FRACTION_BITS - 32);
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << SUM_FRACTION_BITS;

  logic [RANK_W-1:0]         mem [DEPTH];
  logic [RANK_W-1:0]         rdata;
  logic [PRECISION_BITS-1:0] raddr, waddr;
  logic [RANK_W-1:0]         wdata;
  logic                      we;

  hll_back_state_t state, state_next;
  logic [CNT_W-1:0]          cnt;
  logic                      rd_v;
  logic [PRECISION_BITS-1:0] cur_addr;
  logic [RANK_W-1:0]         cur_rank;
  logic [ACC_W-1:0]          acc;
  logic [CNT_W-1:0]          nz;
  logic [LIM_W-1:0]          lim;
  logic [NUM_W-1:0]          nsh;
  logic [NUM_W-1:0]          quo;
  logic [ACC_W-1:0]          rem;
  logic [DCNT_W-1:0]         dcnt;
  logic [EST_W-1:0]          res_val;
  logic                      res_lc;

  logic                      lc_start, lc_done;
  logic [EST_W-1:0]          lc_result;
  logic [ACC_W+2:0]          acc5;
  logic                      twice_le;
  logic [ACC_W:0]            remsh, remdiff;
  logic                      ge;
  logic                      rnd;
  logic [NUM_W:0]            qr;
  logic                      sat;
  logic                      load;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign acc5     = (ACC_W+3)'({acc, 2'b00}) + (ACC_W+3)'(acc);
  assign twice_le = LIM_W'({NUM, 1'b0}) <= lim;
  assign remsh    = {rem, nsh[NUM_W-1]};
  assign remdiff  = remsh - {1'b0, acc};
  assign ge       = remsh >= {1'b0, acc};
  assign rnd      = {rem, 1'b0} >= {1'b0, acc};
  assign qr       = {1'b0, quo} + (NUM_W+1)'(rnd);
  assign sat      = |qr[NUM_W:EST_W];
  assign clearing = (state == B_CLEAR);
  assign load     = (state == B_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = cnt[PRECISION_BITS-1:0];
    wdata      = '0;
    raddr      = job.slot[PRECISION_BITS-1:0];
    lc_start   = 1'b0;
    unique case (state)
      B_CLEAR: begin
        we = 1'b1;
        if (cnt == CNT_W'(DEPTH - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = job.is_est ? B_SUM : B_UPD;
        end
      end
      B_UPD: begin
        waddr      = cur_addr;
        wdata      = cur_rank;
        we         = cur_rank > rdata;
        state_next = B_IDLE;
      end
      B_SUM: begin
        raddr = cnt[PRECISION_BITS-1:0];
        if (cnt == CNT_W'(DEPTH) && !rd_v) state_next = B_LIM;
      end
      B_LIM: state_next = B_TEST;
      B_TEST: begin
        if (acc == '0) begin
          state_next = B_DONE;
        end else if (nz != '0 && twice_le) begin
          lc_start   = 1'b1;
          state_next = B_LC;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV:   if (dcnt == '0) state_next = B_ROUND;
      B_ROUND: state_next = B_DONE;
      B_LC:    if (lc_done) state_next = B_DONE;
      B_DONE:  if (!out_valid || !out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rd_v <= 1'b0;
    end else begin
      case (state)
        B_CLEAR: cnt <= cnt + CNT_W'(1);
        B_IDLE: begin
          cnt  <= '0;
          rd_v <= 1'b0;
        end
        B_SUM: begin
          if (cnt != CNT_W'(DEPTH)) begin
            cnt  <= cnt + CNT_W'(1);
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur_addr <= job.slot[PRECISION_BITS-1:0];
        cur_rank <= job.rank;
        acc      <= '0;
        nz       <= '0;
      end
      B_SUM: begin
        if (rd_v) begin
          // 2^-rank, zero once the rank is past the fraction bits
          acc <= acc + (ONE >> rdata);
          if (rdata == '0) nz <= nz + CNT_W'(1);
        end
      end
      B_LIM: lim <= LIM_W'(acc5) << PRECISION_BITS;
      B_TEST: begin
        nsh     <= NUM;
        quo     <= '0;
        rem     <= '0;
        dcnt    <= DCNT_W'(NUM_W - 1);
        res_val <= '1;
        res_lc  <= 1'b0;
      end
      B_DIV: begin
        rem  <= ge ? remdiff[ACC_W-1:0] : remsh[ACC_W-1:0];
        quo  <= {quo[NUM_W-2:0], ge};
        nsh  <= {nsh[NUM_W-2:0], 1'b0};
        dcnt <= dcnt - DCNT_W'(1);
      end
      B_ROUND: res_val <= sat ? '1 : qr[EST_W-1:0];
      B_LC: begin
        if (lc_done) begin
          res_val <= lc_result;
          res_lc  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      estimate             <= res_val;
      used_linear_counting <= res_lc;
    end
  end

  hll_lcount #(
    .PRECISION_BITS(PRECISION_BITS)
  ) u_lcount (
    .clk    (clk),
    .rst    (rst),
    .start  (lc_start),
    .zeros  (nz),
    .done   (lc_done),
    .result (lc_result)
  );

endmodule

FILE: rtl/core/hll_fifo.sv
// short job queue between front and back
module hll_fifo import hll_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hll_job_t push_job,
  input  logic     pop,
  output hll_job_t head,
  output logic     not_empty,
  output logic     full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  hll_job_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

FILE: rtl/core/hll_front.sv
// front end: accepts commands, forms slot and rank, drops no-op commands
module hll_front import hll_pkg::*; #(
  parameter int PRECISION_BITS = PRECISION_BITS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [HASH_W-1:0]  hash_value,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [RANK_W-1:0]  entry_rank,
  input  logic               queue_full,
  input  logic               clearing,
  output logic               push,
  output hll_job_t           job
);

  localparam int REST_W = HASH_W - PRECISION_BITS;

  logic              accept;
  logic              in_range;
  logic [RANK_W-1:0] add_rank;

  // one plus leading zeros of the bits below the slot, capped at REST_W + 1
  always_comb begin
    add_rank = RANK_W'(REST_W + 1);
    for (int i = 0; i < REST_W; i++) begin
      if (hash_value[i]) add_rank = RANK_W'(REST_W - i);
    end
  end

  assign in_stall = queue_full || clearing;
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(entry_index) >> PRECISION_BITS) == 32'd0;

  always_comb begin
    push = 1'b0;
    job  = '0;
    unique case (cmd)
      CMD_ADD: begin
        push        = accept;
        job.slot    = MAX_PRECISION'(hash_value >> REST_W);
        job.rank    = add_rank;
      end
      CMD_MERGE: begin
        push        = accept && in_range;
        job.slot    = MAX_PRECISION'(entry_index);
        job.rank    = entry_rank;
      end
      CMD_EST: begin
        push        = accept;
        job.is_est  = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/hyperloglog_cardinality_sketch.sv
// top level of the hyperloglog cardinality sketch
// hyperloglog sketch over 2^PRECISION_BITS six-bit rank entries. the front
// takes one command item per cycle, while in_stall is low, into a four-deep
// job queue; the back drains it. add and merge each pass the back's idle and
// update states (read, then conditional write on the rank table, which has one
// read and one write port), so a long burst of updates fills the queue and
// then stalls the front. an estimate walks the table, then either runs a
// restoring divider over 2*PRECISION_BITS + SUM_FRACTION_BITS quotient bits
// plus a rounding step, or the linear-counting unit (32 squarings and two
// multiplies), or, for an all-zero sum, gives an all-ones estimate. after
// reset the table is cleared one entry per cycle, which holds in_stall high
// while it runs. cmd 3 is taken and ignored, add and merge give no result,
// and a merge to an entry beyond the table is dropped.
module hyperloglog_cardinality_sketch import hll_pkg::*; #(
  parameter int PRECISION_BITS    = PRECISION_BITS_DEF,
  parameter int SUM_FRACTION_BITS = SUM_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [HASH_W-1:0]  hash_value,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [RANK_W-1:0]  entry_rank,
  // estimate channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [EST_W-1:0]   estimate,
  output logic               used_linear_counting
);

  logic     push, pop, queue_full, queue_ready, clearing;
  hll_job_t push_job, head_job;

  // classify and form slot / rank
  hll_front #(
    .PRECISION_BITS(PRECISION_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .hash_value  (hash_value),
    .entry_index (entry_index),
    .entry_rank  (entry_rank),
    .queue_full  (queue_full),
    .clearing    (clearing),
    .push        (push),
    .job         (push_job)
  );

  // decouples the one-per-cycle front from the slower back
  hll_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head_job),
    .not_empty (queue_ready),
    .full      (queue_full)
  );

  // rank table, estimate datapath and the output register
  hll_back #(
    .PRECISION_BITS    (PRECISION_BITS),
    .SUM_FRACTION_BITS (SUM_FRACTION_BITS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .job_valid            (queue_ready),
    .job                  (head_job),
    .pop                  (pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .estimate             (estimate),
    .used_linear_counting (used_linear_counting)
  );

endmodule

FILE: rtl/core/hll_checker.sv
// port-level checks of the hyperloglog sketch, bound to the top level
`include "assert_macros.svh"

module hll_checker import hll_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [EST_W-1:0] estimate,
  input logic             used_linear_counting
);

  // a stalled item stays offered
  `HLL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "estimate item dropped while stalled")

  // reset starts the clearing pass, so no item is taken right after it
  `HLL_ASSERT_RST(a_clear_stall, rst |=> in_stall, "input not stalled during table clear")

  // reset leaves no estimate pending
  `HLL_ASSERT_RST(a_rst_out, rst |=> !out_valid, "estimate item present after reset")

  // linear counting never exceeds m*ln(m), far below 2^32
  `HLL_ASSERT(a_lc_range, out_valid && used_linear_counting |-> estimate[63:32] == 32'd0, "linear-counting estimate out of range")

endmodule

bind hyperloglog_cardinality_sketch hll_checker u_hll_checker (.*);
